// ===== rtl/ttf_pkg.sv =====
// Shared types, widths and register codes for the IoU track table filter.
// No dependencies; used by ttf_match_unit and iou_track_table_filter_unit.
package ttf_pkg;

    localparam int MAX_TRACKS = 32;
    localparam int COORD_BITS = 11;
    localparam int SCORE_BITS = 16;
    localparam int HITS_BITS  = 8;
    localparam int MISS_BITS  = 4;
    localparam int IDX_W      = $clog2(MAX_TRACKS);
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
    localparam int AREA_W     = 2 * COORD_BITS;
    localparam int UNI_W      = AREA_W + 1;
    localparam int PROD_W     = AREA_W + UNI_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_IOU  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CANDIDATE  = 2'd3;

    localparam logic [7:0]           RST_MATCH_IOU  = 8'd64;
    localparam logic [MISS_BITS-1:0] RST_MAX_MISSES = 4'd5;
    localparam logic [HITS_BITS-1:0] RST_CONFIRM    = 8'd2;
    localparam logic [HITS_BITS-1:0] RST_CANDIDATE  = 8'd1;

    // IoU threshold denominator (1/256 units)
    localparam logic [UNI_W-1:0] THR_DEN = UNI_W'(256);

    // one track table row as stored in memory
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [SCORE_BITS-1:0] score;
        logic [HITS_BITS-1:0]  hits;
        logic [MISS_BITS-1:0]  misses;
    } row_t;

    // one result item
    typedef struct packed {
        logic                  present;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [SCORE_BITS-1:0] score;
        logic                  confirmed;
        logic                  last;
        logic                  overflow;
    } out_t;

endpackage

// ===== rtl/ttf_match_unit.sv =====
// Four-stage IoU compare: decides whether detection/track IoU beats bn/bd.
// Depends on ttf_pkg (row_t, widths).
module ttf_match_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  ttf_pkg::row_t                det,
    input  ttf_pkg::row_t                trk,
    input  logic [ttf_pkg::AREA_W-1:0]   best_num,
    input  logic [ttf_pkg::UNI_W-1:0]    best_den,
    output logic                         done,
    output logic                         gt,
    output logic [ttf_pkg::AREA_W-1:0]   inter,
    output logic [ttf_pkg::UNI_W-1:0]    uni
);

    localparam int CW = ttf_pkg::COORD_BITS;

    logic [3:0] vld_reg;

    logic [CW:0]                 iw_reg, ih_reg;
    logic [ttf_pkg::AREA_W-1:0]  area_d_reg, area_t_reg;
    logic [ttf_pkg::AREA_W-1:0]  inter_reg, inter2_reg;
    logic [ttf_pkg::UNI_W-1:0]   uni_reg, uni2_reg;
    logic [ttf_pkg::PROD_W-1:0]  p_cand_reg, p_best_reg;
    logic                        zero_reg;
    logic                        gt_reg;

    logic [CW:0] l_c, t_c, r_c, b_c, d_r, d_b, t_r, t_b;
    logic [2*CW+1:0] iwh_c;
    logic [ttf_pkg::UNI_W-1:0] sum_c;

    // stage 1 geometry
    always_comb
    begin
        d_r = {1'b0, det.x} + {1'b0, det.w};
        d_b = {1'b0, det.y} + {1'b0, det.h};
        t_r = {1'b0, trk.x} + {1'b0, trk.w};
        t_b = {1'b0, trk.y} + {1'b0, trk.h};
        l_c = (det.x > trk.x) ? {1'b0, det.x} : {1'b0, trk.x};
        t_c = (det.y > trk.y) ? {1'b0, det.y} : {1'b0, trk.y};
        r_c = (d_r < t_r) ? d_r : t_r;
        b_c = (d_b < t_b) ? d_b : t_b;
        iwh_c = iw_reg * ih_reg;
        sum_c = {1'b0, area_d_reg} + {1'b0, area_t_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: overlap extents and areas
        iw_reg     <= (r_c > l_c) ? (r_c - l_c) : '0;
        ih_reg     <= (b_c > t_c) ? (b_c - t_c) : '0;
        area_d_reg <= det.w * det.h;
        area_t_reg <= trk.w * trk.h;
        // stage 2: intersection and union
        inter_reg  <= iwh_c[ttf_pkg::AREA_W-1:0];
        uni_reg    <= sum_c - {1'b0, iwh_c[ttf_pkg::AREA_W-1:0]};
        // stage 3: cross products
        p_cand_reg <= inter_reg * best_den;
        p_best_reg <= best_num * uni_reg;
        zero_reg   <= (uni_reg == '0);
        inter2_reg <= inter_reg;
        uni2_reg   <= uni_reg;
        // stage 4: compare
        gt_reg     <= !zero_reg && (p_cand_reg > p_best_reg);
    end

    // results held one more stage so gt lines up with its ratio
    logic [ttf_pkg::AREA_W-1:0] inter3_reg;
    logic [ttf_pkg::UNI_W-1:0]  uni3_reg;

    always_ff @(posedge clk)
    begin
        inter3_reg <= inter2_reg;
        uni3_reg   <= uni2_reg;
    end

    assign done  = vld_reg[3];
    assign gt    = gt_reg;
    assign inter = inter3_reg;
    assign uni   = uni3_reg;

endmodule

// ===== rtl/iou_track_table_filter_unit.sv =====
// Top level of the IoU track table filter: FSM, track memory, result output.
// Depends on ttf_pkg and ttf_match_unit.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item per detection
//   (operation 0) or an end-of-frame marker (operation 1). Detections give
//   no result. An end-of-frame item gives the frame's reported tracks in
//   table order on the output channel (out_valid/out_stall), is_last on the
//   final one, or one empty marker (track_present 0) if none is reported.
//   A detection holds in_stall while it steps, for each unmatched old track
//   scanned, through read, latch, launch and the four-stage IoU compare,
//   serialized by the running best ratio; an already matched old track is
//   only read and skipped. End of frame holds in_stall through the
//   compaction sweep (a read per stored track, a write-back per kept one)
//   and while it waits on a stalled output.
//   in_stall is high while an item is being worked on. A stalled output
//   item holds; the sweep waits on it only when it must push another item.
//   Reset empties the table, restores register defaults, clears the output.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
//   must do so only when idle, as the block does not enforce it.
module iou_track_table_filter_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [ttf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [ttf_pkg::COORD_BITS-1:0]    box_x,
    input  logic [ttf_pkg::COORD_BITS-1:0]    box_y,
    input  logic [ttf_pkg::COORD_BITS-1:0]    box_w,
    input  logic [ttf_pkg::COORD_BITS-1:0]    box_h,
    input  logic [ttf_pkg::SCORE_BITS-1:0]    det_score,
    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              track_present,
    output logic [ttf_pkg::COORD_BITS-1:0]    track_x,
    output logic [ttf_pkg::COORD_BITS-1:0]    track_y,
    output logic [ttf_pkg::COORD_BITS-1:0]    track_w,
    output logic [ttf_pkg::COORD_BITS-1:0]    track_h,
    output logic [ttf_pkg::SCORE_BITS-1:0]    track_score,
    output logic                              is_confirmed,
    output logic                              is_last,
    output logic                              table_overflow
);

    localparam int IW = ttf_pkg::IDX_W;
    localparam int CW = ttf_pkg::CNT_W;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_D_RD   = 9'b000000010,
        ST_D_LAT  = 9'b000000100,
        ST_D_WAIT = 9'b000001000,
        ST_D_UPD  = 9'b000010000,
        ST_E_RD   = 9'b000100000,
        ST_E_PROC = 9'b001000000,
        ST_E_FIN  = 9'b010000000,
        ST_D_LAUN = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [7:0]                     thr_reg;
    logic [ttf_pkg::MISS_BITS-1:0]  max_miss_reg;
    logic [ttf_pkg::HITS_BITS-1:0]  confirm_reg, cand_reg;

    // table bookkeeping
    localparam int MAX_T = ttf_pkg::MAX_TRACKS;
    logic [CW-1:0]          cnt_reg, old_cnt_reg, j_reg, k_reg;
    logic [MAX_T-1:0]       matched_reg;
    logic                   ovf_reg;

    // detection context
    ttf_pkg::row_t              det_reg, cur_row_reg, best_row_reg;
    logic [ttf_pkg::AREA_W-1:0] bn_reg;
    logic [ttf_pkg::UNI_W-1:0]  bd_reg;
    logic                       best_found_reg;
    logic [IW-1:0]              best_idx_reg;

    // output staging
    ttf_pkg::out_t  pend_reg, out_reg;
    logic           pend_valid_reg, out_valid_reg;

    // track memory
    ttf_pkg::row_t  mem [MAX_T];
    ttf_pkg::row_t  rdata_reg, mem_wdata;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;

    // match unit
    logic                       mu_start, mu_done, mu_gt;
    logic [ttf_pkg::AREA_W-1:0] mu_inter;
    logic [ttf_pkg::UNI_W-1:0]  mu_uni;

    ttf_match_unit u_match
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mu_start),
        .det      (det_reg),
        .trk      (cur_row_reg),
        .best_num (bn_reg),
        .best_den (bd_reg),
        .done     (mu_done),
        .gt       (mu_gt),
        .inter    (mu_inter),
        .uni      (mu_uni)
    );

    logic in_acc, out_free;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // end-of-frame sweep decisions on the row just read
    logic                          inc_c, keep_c, conf_c, report_c, go_c;
    logic [ttf_pkg::MISS_BITS-1:0] nmiss_c;
    ttf_pkg::out_t                 item_c;

    always_comb
    begin
        inc_c    = (j_reg < old_cnt_reg) && !matched_reg[j_reg[IW-1:0]]
                   && (rdata_reg.misses != '1);
        nmiss_c  = rdata_reg.misses + ttf_pkg::MISS_BITS'(inc_c);
        keep_c   = (nmiss_c <= max_miss_reg);
        conf_c   = (rdata_reg.hits >= confirm_reg);
        report_c = keep_c && (conf_c || (rdata_reg.hits >= cand_reg));
        go_c     = !(report_c && pend_valid_reg && !out_free);
        item_c.present   = 1'b1;
        item_c.x         = rdata_reg.x;
        item_c.y         = rdata_reg.y;
        item_c.w         = rdata_reg.w;
        item_c.h         = rdata_reg.h;
        item_c.score     = rdata_reg.score;
        item_c.confirmed = conf_c;
        item_c.last      = 1'b0;
        item_c.overflow  = ovf_reg;
    end

    // output register load and the frame's final item
    logic          out_load_c;
    ttf_pkg::out_t fin_item_c;

    always_comb
    begin
        out_load_c = ((state_reg == ST_E_PROC) && go_c && report_c && pend_valid_reg)
                     || ((state_reg == ST_E_FIN) && out_free);
        if (pend_valid_reg)
        begin
            fin_item_c = pend_reg;
        end
        else
        begin
            fin_item_c          = '0;
            fin_item_c.overflow = ovf_reg;
        end
        fin_item_c.last = 1'b1;
    end

    // matched-track update row
    ttf_pkg::row_t upd_row_c;
    logic [ttf_pkg::COORD_BITS:0] sx_c, sy_c, sw_c, sh_c;

    always_comb
    begin
        sx_c = {1'b0, det_reg.x} + {1'b0, best_row_reg.x};
        sy_c = {1'b0, det_reg.y} + {1'b0, best_row_reg.y};
        sw_c = {1'b0, det_reg.w} + {1'b0, best_row_reg.w};
        sh_c = {1'b0, det_reg.h} + {1'b0, best_row_reg.h};
        upd_row_c.x      = sx_c[ttf_pkg::COORD_BITS:1];
        upd_row_c.y      = sy_c[ttf_pkg::COORD_BITS:1];
        upd_row_c.w      = sw_c[ttf_pkg::COORD_BITS:1];
        upd_row_c.h      = sh_c[ttf_pkg::COORD_BITS:1];
        upd_row_c.score  = (det_reg.score > best_row_reg.score) ? det_reg.score
                                                                : best_row_reg.score;
        upd_row_c.hits   = (best_row_reg.hits == '1) ? best_row_reg.hits
                                                     : best_row_reg.hits + 1'b1;
        upd_row_c.misses = '0;
    end

    // next state, memory write, match unit launch
    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = k_reg[IW-1:0];
        mem_wdata  = rdata_reg;
        mu_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = operation ? ST_E_RD : ST_D_RD;
                end
            end
            ST_D_RD:
            begin
                if (j_reg >= old_cnt_reg)
                begin
                    state_next = ST_D_UPD;
                end
                else if (!matched_reg[j_reg[IW-1:0]])
                begin
                    state_next = ST_D_LAT;
                end
            end
            ST_D_LAT:
            begin
                state_next = ST_D_LAUN;
            end
            ST_D_LAUN:
            begin
                mu_start   = 1'b1;
                state_next = ST_D_WAIT;
            end
            ST_D_WAIT:
            begin
                if (mu_done)
                begin
                    state_next = ST_D_RD;
                end
            end
            ST_D_UPD:
            begin
                if (best_found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = best_idx_reg;
                    mem_wdata = upd_row_c;
                end
                else if (cnt_reg < CW'(MAX_T))
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = cnt_reg[IW-1:0];
                    mem_wdata        = det_reg;
                    mem_wdata.hits   = ttf_pkg::HITS_BITS'(1);
                    mem_wdata.misses = '0;
                end
                state_next = ST_IDLE;
            end
            ST_E_RD:
            begin
                state_next = (j_reg == cnt_reg) ? ST_E_FIN : ST_E_PROC;
            end
            ST_E_PROC:
            begin
                if (go_c)
                begin
                    mem_we           = keep_c;
                    mem_wdata        = rdata_reg;
                    mem_wdata.misses = nmiss_c;
                    state_next       = ST_E_RD;
                end
            end
            ST_E_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // track memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[j_reg[IW-1:0]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= ttf_pkg::RST_MATCH_IOU;
            max_miss_reg   <= ttf_pkg::RST_MAX_MISSES;
            confirm_reg    <= ttf_pkg::RST_CONFIRM;
            cand_reg       <= ttf_pkg::RST_CANDIDATE;
            cnt_reg        <= '0;
            old_cnt_reg    <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            matched_reg    <= '0;
            ovf_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ttf_pkg::CFG_MATCH_IOU:  thr_reg      <= cfg_wdata;
                    ttf_pkg::CFG_MAX_MISSES: max_miss_reg <= cfg_wdata[ttf_pkg::MISS_BITS-1:0];
                    ttf_pkg::CFG_CONFIRM:    confirm_reg  <= cfg_wdata;
                    ttf_pkg::CFG_CANDIDATE:  cand_reg     <= cfg_wdata;
                    default:                 ;
                endcase
            end

            // output valid: set on a load, cleared once taken
            if (out_load_c)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    j_reg          <= '0;
                    k_reg          <= '0;
                    best_found_reg <= 1'b0;
                    pend_valid_reg <= 1'b0;
                end
                ST_D_RD:
                begin
                    if (j_reg < old_cnt_reg && matched_reg[j_reg[IW-1:0]])
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_D_WAIT:
                begin
                    if (mu_done)
                    begin
                        j_reg <= j_reg + 1'b1;
                        if (mu_gt)
                        begin
                            best_found_reg <= 1'b1;
                        end
                    end
                end
                ST_D_UPD:
                begin
                    if (best_found_reg)
                    begin
                        matched_reg[best_idx_reg] <= 1'b1;
                    end
                    else if (cnt_reg < CW'(MAX_T))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_E_PROC:
                begin
                    if (go_c)
                    begin
                        j_reg <= j_reg + 1'b1;
                        if (keep_c)
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                        if (report_c)
                        begin
                            pend_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_E_FIN:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        cnt_reg        <= k_reg;
                        old_cnt_reg    <= k_reg;
                        matched_reg    <= '0;
                        ovf_reg        <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            det_reg.x      <= box_x;
            det_reg.y      <= box_y;
            det_reg.w      <= box_w;
            det_reg.h      <= box_h;
            det_reg.score  <= det_score;
            det_reg.hits   <= '0;
            det_reg.misses <= '0;
            bn_reg         <= ttf_pkg::AREA_W'(thr_reg);
            bd_reg         <= ttf_pkg::THR_DEN;
        end
        if (state_reg == ST_D_LAT)
        begin
            cur_row_reg <= rdata_reg;
        end
        if (state_reg == ST_D_WAIT && mu_done && mu_gt)
        begin
            bn_reg       <= mu_inter;
            bd_reg       <= mu_uni;
            best_row_reg <= cur_row_reg;
            best_idx_reg <= j_reg[IW-1:0];
        end
        if (state_reg == ST_E_PROC && go_c && report_c)
        begin
            pend_reg <= item_c;
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
            end
        end
        if (state_reg == ST_E_FIN && out_free)
        begin
            out_reg <= fin_item_c;
        end
    end

    assign out_valid      = out_valid_reg;
    assign track_present  = out_reg.present;
    assign track_x        = out_reg.x;
    assign track_y        = out_reg.y;
    assign track_w        = out_reg.w;
    assign track_h        = out_reg.h;
    assign track_score    = out_reg.score;
    assign is_confirmed   = out_reg.confirmed;
    assign is_last        = out_reg.last;
    assign table_overflow = out_reg.overflow;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_T))
        else $error("track count beyond table size");

    a_old_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        old_cnt_reg <= cnt_reg)
        else $error("frame-start count above current count");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E_PROC) |-> (k_reg <= j_reg))
        else $error("compaction write ahead of read");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E_FIN && out_free) |=> (out_valid_reg && out_reg.last))
        else $error("frame end without last item");

endmodule

// ===== tb/tb_iou_track_table_filter_unit.sv =====
// Self-checking testbench for iou_track_table_filter_unit: directed frames, then random frames.
// Holds its own model of the track table. Depends on ttf_pkg and the RTL top level only.
module tb_iou_track_table_filter_unit;

    localparam int MAX_TRACKS = ttf_pkg::MAX_TRACKS;
    localparam int COORD_BITS = ttf_pkg::COORD_BITS;
    localparam int SCORE_BITS = ttf_pkg::SCORE_BITS;
    localparam int HITS_BITS  = ttf_pkg::HITS_BITS;
    localparam int MISS_BITS  = ttf_pkg::MISS_BITS;
    localparam int CFG_IDX_W  = ttf_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ttf_pkg::CFG_DATA_W;

    localparam int RUN_LIMIT  = 600000;
    localparam int SETTLE     = 260;   // longest detection scan plus margin
    localparam int REPORT_CAP = 32;
    localparam int HOLD_LEN   = 400;

    localparam ttf_pkg::out_t EMPTY_FRAME = '{present: 1'b0, x: '0, y: '0, w: '0, h: '0,
                                              score: '0, confirmed: 1'b0, last: 1'b1,
                                              overflow: 1'b0};

    typedef enum logic {OP_DETECT = 1'b0, OP_END_FRAME = 1'b1} op_t;

    typedef struct {
        op_t                   op;
        logic [COORD_BITS-1:0] x, y, w, h;
        logic [SCORE_BITS-1:0] s;
        bit                    typed;
        ttf_pkg::out_t         result;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = 1'b0;
    logic [COORD_BITS-1:0] box_x = '0, box_y = '0, box_w = '0, box_h = '0;
    logic [SCORE_BITS-1:0] det_score = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  track_present, is_confirmed, is_last, table_overflow;
    logic [COORD_BITS-1:0] track_x, track_y, track_w, track_h;
    logic [SCORE_BITS-1:0] track_score;

    iou_track_table_filter_unit u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // shadow track table and registers
    logic                  trk_valid   [MAX_TRACKS];
    logic [COORD_BITS-1:0] trk_x       [MAX_TRACKS];
    logic [COORD_BITS-1:0] trk_y       [MAX_TRACKS];
    logic [COORD_BITS-1:0] trk_w       [MAX_TRACKS];
    logic [COORD_BITS-1:0] trk_h       [MAX_TRACKS];
    logic [SCORE_BITS-1:0] trk_score   [MAX_TRACKS];
    logic [HITS_BITS-1:0]  trk_hits    [MAX_TRACKS];
    logic [MISS_BITS-1:0]  trk_misses  [MAX_TRACKS];
    logic                  trk_matched [MAX_TRACKS];
    logic                  trk_fresh   [MAX_TRACKS];
    logic                  drop_seen;
    logic [7:0]            iou_thr_q8;
    logic [MISS_BITS-1:0]  miss_limit;
    logic [HITS_BITS-1:0]  confirm_min, candidate_min;

    ttf_pkg::out_t frame_report_q[$];
    int   errors = 0;
    int   items_sent = 0;
    int   cycle_count = 0;
    int   sender_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_req = 1'b0;
    bit   typed_pending = 1'b0;
    ttf_pkg::out_t typed_result;

    initial
    begin
        for (int j = 0; j < MAX_TRACKS; j++)
        begin
            trk_valid[j] = 1'b0;
            trk_matched[j] = 1'b0;
            trk_fresh[j] = 1'b0;
        end
        drop_seen = 1'b0;
        iou_thr_q8 = ttf_pkg::RST_MATCH_IOU;
        miss_limit = ttf_pkg::RST_MAX_MISSES;
        confirm_min = ttf_pkg::RST_CONFIRM;
        candidate_min = ttf_pkg::RST_CANDIDATE;
    end

    // greedy match of one detection against old, unmatched tracks
    function automatic void apply_detection(input int unsigned x, y, w, h,
                                            input logic [SCORE_BITS-1:0] s);
        longint unsigned best_n, best_d, inter, uni;
        int unsigned l, t, r, b, iw, ih;
        int best;
        best_n = iou_thr_q8;
        best_d = 256;
        best = -1;
        for (int j = 0; j < MAX_TRACKS; j++)
        begin
            if (!trk_valid[j] || trk_matched[j] || trk_fresh[j])
                continue;
            l = (x > trk_x[j]) ? x : trk_x[j];
            t = (y > trk_y[j]) ? y : trk_y[j];
            r = (x + w < trk_x[j] + trk_w[j]) ? x + w : trk_x[j] + trk_w[j];
            b = (y + h < trk_y[j] + trk_h[j]) ? y + h : trk_y[j] + trk_h[j];
            iw = (r > l) ? r - l : 0;
            ih = (b > t) ? b - t : 0;
            inter = longint'(iw) * ih;
            uni = longint'(w) * h + longint'(trk_w[j]) * trk_h[j] - inter;
            if (uni == 0)
                continue;
            if (inter * best_d > best_n * uni)
            begin
                best_n = inter;
                best_d = uni;
                best = j;
            end
        end
        if (best >= 0)
        begin
            trk_x[best] = COORD_BITS'((x + trk_x[best]) >> 1);
            trk_y[best] = COORD_BITS'((y + trk_y[best]) >> 1);
            trk_w[best] = COORD_BITS'((w + trk_w[best]) >> 1);
            trk_h[best] = COORD_BITS'((h + trk_h[best]) >> 1);
            if (s > trk_score[best])
                trk_score[best] = s;
            if (trk_hits[best] != 8'd255)
                trk_hits[best]++;
            trk_misses[best] = '0;
            trk_matched[best] = 1'b1;
            return;
        end
        for (int j = 0; j < MAX_TRACKS; j++)
        begin
            if (!trk_valid[j])
            begin
                trk_valid[j] = 1'b1;
                trk_x[j] = COORD_BITS'(x);
                trk_y[j] = COORD_BITS'(y);
                trk_w[j] = COORD_BITS'(w);
                trk_h[j] = COORD_BITS'(h);
                trk_score[j] = s;
                trk_hits[j] = 8'd1;
                trk_misses[j] = '0;
                trk_matched[j] = 1'b0;
                trk_fresh[j] = 1'b1;
                return;
            end
        end
        drop_seen = 1'b1;
    endfunction

    // age, prune, compact, then queue the frame's report
    function automatic void close_frame();
        int   k;
        logic ovf;
        logic conf;
        ttf_pkg::out_t o;
        ttf_pkg::out_t batch[$];
        k = 0;
        ovf = drop_seen;
        for (int j = 0; j < MAX_TRACKS; j++)
            if (trk_valid[j] && !trk_fresh[j] && !trk_matched[j] && trk_misses[j] != 4'd15)
                trk_misses[j]++;
        for (int j = 0; j < MAX_TRACKS; j++)
        begin
            if (!trk_valid[j] || trk_misses[j] > miss_limit)
                continue;
            trk_valid[k] = 1'b1;
            trk_x[k] = trk_x[j];
            trk_y[k] = trk_y[j];
            trk_w[k] = trk_w[j];
            trk_h[k] = trk_h[j];
            trk_score[k] = trk_score[j];
            trk_hits[k] = trk_hits[j];
            trk_misses[k] = trk_misses[j];
            k++;
        end
        for (int j = 0; j < MAX_TRACKS; j++)
        begin
            if (j >= k)
                trk_valid[j] = 1'b0;
            trk_matched[j] = 1'b0;
            trk_fresh[j] = 1'b0;
        end
        drop_seen = 1'b0;
        for (int j = 0; j < k && batch.size() < REPORT_CAP; j++)
        begin
            conf = (trk_hits[j] >= confirm_min);
            if (!conf && trk_hits[j] < candidate_min)
                continue;
            o = '{present: 1'b1, x: trk_x[j], y: trk_y[j], w: trk_w[j], h: trk_h[j],
                  score: trk_score[j], confirmed: conf, last: 1'b0, overflow: ovf};
            batch = {batch, o};
        end
        if (batch.size() == 0)
        begin
            o = EMPTY_FRAME;
            o.overflow = ovf;
            batch = {batch, o};
        end
        batch[batch.size() - 1].last = 1'b1;
        frame_report_q = {frame_report_q, batch};
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", field, got, want, cycle_count);
        errors++;
    endtask

    // accept side: feed the model; result side: compare with oldest expectation
    always @(posedge clk)
    begin
        ttf_pkg::out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (operation == OP_END_FRAME)
                begin
                    close_frame();
                    if (typed_pending)
                    begin
                        frame_report_q[frame_report_q.size() - 1] = typed_result;
                        typed_pending = 1'b0;
                    end
                end
                else
                    apply_detection(box_x, box_y, box_w, box_h, det_score);
            end
            if (out_valid && !out_stall)
            begin
                if (frame_report_q.size() == 0)
                    report_mismatch("unexpected item, present", track_present, 0);
                else
                begin
                    want = frame_report_q.pop_front();
                    if (track_present !== want.present)
                        report_mismatch("track_present", track_present, want.present);
                    if (track_x !== want.x)
                        report_mismatch("track_x", track_x, want.x);
                    if (track_y !== want.y)
                        report_mismatch("track_y", track_y, want.y);
                    if (track_w !== want.w)
                        report_mismatch("track_w", track_w, want.w);
                    if (track_h !== want.h)
                        report_mismatch("track_h", track_h, want.h);
                    if (track_score !== want.score)
                        report_mismatch("track_score", track_score, want.score);
                    if (is_confirmed !== want.confirmed)
                        report_mismatch("is_confirmed", is_confirmed, want.confirmed);
                    if (is_last !== want.last)
                        report_mismatch("is_last", is_last, want.last);
                    if (table_overflow !== want.overflow)
                        report_mismatch("table_overflow", table_overflow, want.overflow);
                end
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(negedge clk)
    begin
        int hold_left;
        if (hold_req)
        begin
            hold_left = HOLD_LEN;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("iou_track_table_filter_unit verification failed");
            $finish;
        end
    end

    task automatic offer(input op_t op, input logic [COORD_BITS-1:0] x, y, w, h,
                         input logic [SCORE_BITS-1:0] s);
        @(negedge clk);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        operation = op;
        box_x = x;
        box_y = y;
        box_w = w;
        box_h = h;
        det_score = s;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // stop sending and wait until every expected item has come out
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (frame_report_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            ttf_pkg::CFG_MATCH_IOU:  iou_thr_q8 = val;
            ttf_pkg::CFG_MAX_MISSES: miss_limit = val[MISS_BITS-1:0];
            ttf_pkg::CFG_CONFIRM:    confirm_min = val;
            ttf_pkg::CFG_CANDIDATE:  candidate_min = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] thr, misses, conf, cand);
        write_reg(ttf_pkg::CFG_MATCH_IOU, thr);
        write_reg(ttf_pkg::CFG_MAX_MISSES, misses);
        write_reg(ttf_pkg::CFG_CONFIRM, conf);
        write_reg(ttf_pkg::CFG_CANDIDATE, cand);
    endtask

    function automatic logic [COORD_BITS-1:0] clip_coord(input int v);
        return (v < 0) ? '0 : (v > 2047) ? 11'd2047 : v[COORD_BITS-1:0];
    endfunction

    // mostly detections near live tracks, some fresh or full-range boxes
    task automatic random_frame();
        int live, j, n;
        logic [COORD_BITS-1:0] x, y, w, h;
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
        begin
            live = 0;
            for (int m = 0; m < MAX_TRACKS; m++)
                live += trk_valid[m];
            if (live > 0 && $urandom_range(99) < 70)
            begin
                j = $urandom_range(live - 1);
                x = clip_coord(int'(trk_x[j]) + $urandom_range(6) - 3);
                y = clip_coord(int'(trk_y[j]) + $urandom_range(6) - 3);
                w = clip_coord(int'(trk_w[j]) + $urandom_range(6) - 3);
                h = clip_coord(int'(trk_h[j]) + $urandom_range(6) - 3);
            end
            else if ($urandom_range(9) == 0)
            begin
                x = COORD_BITS'($urandom);
                y = COORD_BITS'($urandom);
                w = COORD_BITS'($urandom);
                h = COORD_BITS'($urandom);
            end
            else
            begin
                x = COORD_BITS'($urandom_range(0, 1900));
                y = COORD_BITS'($urandom_range(0, 1900));
                w = COORD_BITS'($urandom_range(1, 120));
                h = COORD_BITS'($urandom_range(1, 120));
            end
            offer(OP_DETECT, x, y, w, h, SCORE_BITS'($urandom));
        end
        offer(OP_END_FRAME, COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COORD_BITS'($urandom), SCORE_BITS'($urandom));
    endtask

    task automatic run_until(input int target);
        while (items_sent < target)
            random_frame();
    endtask

    stim_row_t dir_rows[$];

    function automatic stim_row_t mk_row(input op_t op, input int x, y, w, h, s);
        stim_row_t r;
        r.op = op;
        r.x = COORD_BITS'(x);
        r.y = COORD_BITS'(y);
        r.w = COORD_BITS'(w);
        r.h = COORD_BITS'(h);
        r.s = SCORE_BITS'(s);
        r.typed = 1'b0;
        r.result = EMPTY_FRAME;
        return r;
    endfunction

    initial
    begin
        stim_row_t r;
        // empty table right after reset gives a lone empty marker
        r = mk_row(OP_END_FRAME, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        dir_rows = {dir_rows, r};
        dir_rows = {dir_rows, mk_row(OP_DETECT, 0, 0, 0, 0, 0)};            // zero-area box
        dir_rows = {dir_rows, mk_row(OP_DETECT, 2047, 2047, 2047, 2047, 65535)};
        dir_rows = {dir_rows, mk_row(OP_DETECT, 100, 100, 50, 50, 1000)};
        dir_rows = {dir_rows, mk_row(OP_DETECT, 400, 300, 8, 8, 7)};
        dir_rows = {dir_rows, mk_row(OP_END_FRAME, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk_row(OP_DETECT, 0, 0, 0, 0, 5)};            // zero union
        dir_rows = {dir_rows, mk_row(OP_DETECT, 102, 101, 50, 50, 2000)};   // match
        dir_rows = {dir_rows, mk_row(OP_DETECT, 2047, 2047, 2047, 2047, 1)}; // full overlap
        dir_rows = {dir_rows, mk_row(OP_DETECT, 401, 300, 8, 8, 9)};
        dir_rows = {dir_rows, mk_row(OP_DETECT, 101, 100, 50, 50, 3)};      // opened new, old taken
        dir_rows = {dir_rows, mk_row(OP_END_FRAME, 0, 0, 0, 0, 0)};
        dir_rows = {dir_rows, mk_row(OP_END_FRAME, 2047, 2047, 2047, 2047, 65535)};
        dir_rows = {dir_rows, mk_row(OP_DETECT, 1024, 1024, 1023, 1023, 32768)};
        dir_rows = {dir_rows, mk_row(OP_DETECT, 683, 1365, 682, 1365, 43690)};
        dir_rows = {dir_rows, mk_row(OP_DETECT, 1365, 682, 1365, 682, 21845)};
        dir_rows = {dir_rows, mk_row(OP_END_FRAME, 0, 0, 0, 0, 0)};
        // run out the miss budget so tracks are pruned
        repeat (7) dir_rows = {dir_rows, mk_row(OP_END_FRAME, 0, 0, 0, 0, 0)};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows, reset register values, no idling
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].typed)
            begin
                typed_result = dir_rows[i].result;
                typed_pending = 1'b1;
            end
            offer(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].w,
                  dir_rows[i].h, dir_rows[i].s);
        end
        drain();

        // lowest threshold and miss budget; sender idles; overfill the table
        set_regs(8'd0, 8'd0, 8'd1, 8'd1);
        sender_idle_pct = 61;
        for (int i = 0; i < 34; i++)
            offer(OP_DETECT, COORD_BITS'((i % 8) * 250 + 3), COORD_BITS'(1700 + (i / 8) * 60),
                  11'd20, 11'd20, SCORE_BITS'($urandom));
        offer(OP_END_FRAME, '0, '0, '0, '0, '0);
        run_until(62);
        drain();

        // highest values: matches rare, nothing reported, misses never prune
        set_regs(8'd255, 8'd15, 8'd255, 8'd255);
        sender_idle_pct = 0;
        recv_stall_pct = 61;
        run_until(76);
        drain();

        // zero hit thresholds; long receiver hold-off while end-of-frame items pile up
        set_regs(8'd128, 8'd2, 8'd0, 8'd0);
        sender_idle_pct = 20;
        recv_stall_pct = 20;
        hold_req = 1'b1;
        repeat (4) offer(OP_END_FRAME, '0, '0, '0, '0, '0);
        run_until(96);
        drain();

        set_regs(8'd64, 8'd14, 8'd3, 8'd2);
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        run_until(116);
        drain();

        if (errors == 0)
            $display("iou_track_table_filter_unit verification clean");
        else
            $display("iou_track_table_filter_unit verification failed");
        $finish;
    end

endmodule
